### src/ptkh_pkg.sv
// ---------------------------------------------------------------------------
// ptkh_pkg
// Shared types and codes for the per-query top-k heap block.
// ---------------------------------------------------------------------------
package ptkh_pkg;

    localparam int KEY_W = 32;
    localparam int SEG_W = 63;
    localparam int OFF_W = 32;

    localparam logic [1:0] MODE_INSERT    = 2'd0;
    localparam logic [1:0] MODE_THRESHOLD = 2'd1;
    localparam logic [1:0] MODE_DRAIN     = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    localparam logic [1:0] REG_KEEP   = 2'd0;
    localparam logic [1:0] REG_ACTIVE = 2'd1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_QUERY = 1'b1;

    // most negative key, stands for -FLT_MAX
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SEG_W-1:0] seg;
        logic [OFF_W-1:0] off;
    } entry_t;

endpackage

### src/ptkh_ram.sv
// ---------------------------------------------------------------------------
// ptkh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ptkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/per_query_topk_heap.sv
// ---------------------------------------------------------------------------
// per_query_topk_heap
// Bounded min-heap per query keeping the best candidates, with one heap
// memory walked by a small sequencer and a single key comparator.
// ---------------------------------------------------------------------------
// Ignored items, bad queries and thresholds on a heap not yet full never leave
// idle; a full heap's threshold reads the root first. Push sifts up level by
// level; replace tests the root and sifts down for a strictly better key; drain
// pops the root and sifts the last entry down for each popped entry, one strobe
// each. Throughput is set by the single heap read port and the one comparator;
// results are strobed for one cycle each, the receiver cannot stall; async
// active-low reset clears fills, registers and sequencer, not the heap
module per_query_topk_heap #(
    parameter int MAX_KEEP    = 64,
    parameter int MAX_QUERIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  query_index,
    input  logic signed [31:0] score_key,
    input  logic [62:0] cand_segment,
    input  logic signed [32:0] row_offset,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        result_valid,
    output logic signed [31:0] out_key,
    output logic [62:0] out_segment,
    output logic [31:0] out_offset,
    output logic        entry_valid,
    output logic        status,
    output logic        last_result
);

    localparam int IW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int FW    = $clog2(MAX_KEEP + 1);
    localparam int CW    = FW + 1;
    localparam int QW    = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
    localparam int DEPTH = MAX_QUERIES * MAX_KEEP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AQW   = ($clog2(MAX_QUERIES + 1) > 5) ? $clog2(MAX_QUERIES + 1) : 5;
    localparam int EW    = $bits(ptkh_pkg::entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT_CMP,
        ST_UP,
        ST_UP_CMP,
        ST_DN,
        ST_DN_L,
        ST_DN_R,
        ST_DN_C,
        ST_TH,
        ST_DR_RD,
        ST_DR_OUT,
        ST_DR_MOV
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] keep_reg;
    logic [4:0] active_reg;
    logic [FW-1:0] fill_reg [MAX_QUERIES];
    logic [QW-1:0] q_reg, q_next;
    logic [FW-1:0] n_reg, n_next;
    logic [IW-1:0] h_reg, h_next;
    logic [IW-1:0] c_reg, c_next;
    logic drain_reg, drain_next;
    ptkh_pkg::entry_t x_reg, x_next;
    ptkh_pkg::entry_t left_reg, left_next;

    logic res_valid_reg, res_valid_next;
    ptkh_pkg::entry_t res_reg, res_next;
    logic res_entry_reg, res_entry_next;
    logic res_status_reg, res_status_next;
    logic res_last_reg, res_last_next;

    logic fill_we;
    logic [QW-1:0] fill_q;
    logic [FW-1:0] fill_val;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    ptkh_pkg::entry_t ram_wdata, ram_rdata;
    logic [EW-1:0] ram_rdata_raw;

    logic [FW-1:0] keep_eff;
    logic [AQW-1:0] act_eff;
    logic [QW-1:0] q_in;
    logic [FW-1:0] n_in;
    logic bad_query;
    logic [CW-1:0] l_idx, r_idx;
    logic [IW-1:0] parent_idx;

    // shared key comparator
    logic [31:0] cmp_a, cmp_b;
    logic cmp_less;
    assign cmp_less = $signed(cmp_a) < $signed(cmp_b);

    ptkh_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );
    assign ram_rdata = ram_rdata_raw;

    always_comb
    begin
        if (keep_reg == 7'd0)
            keep_eff = FW'(1);
        else if (int'(keep_reg) > MAX_KEEP)
            keep_eff = FW'(MAX_KEEP);
        else
            keep_eff = FW'(keep_reg);
        if (active_reg == 5'd0)
            act_eff = AQW'(1);
        else if (int'(active_reg) > MAX_QUERIES)
            act_eff = AQW'(MAX_QUERIES);
        else
            act_eff = AQW'(active_reg);
    end

    assign bad_query  = AQW'(query_index) >= act_eff;
    assign q_in       = QW'(query_index);
    assign n_in       = fill_reg[q_in];
    assign l_idx      = (CW'(h_reg) << 1) + CW'(1);
    assign r_idx      = l_idx + CW'(1);
    assign parent_idx = IW'((h_reg - IW'(1)) >> 1);

    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        n_next          = n_reg;
        h_next          = h_reg;
        c_next          = c_reg;
        drain_next      = drain_reg;
        x_next          = x_reg;
        left_next       = left_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        fill_we         = 1'b0;
        fill_q          = q_reg;
        fill_val        = '0;
        ram_we          = 1'b0;
        ram_waddr       = AW'(int'(q_reg) * MAX_KEEP + int'(h_reg));
        ram_wdata       = x_reg;
        ram_raddr       = AW'(int'(q_reg) * MAX_KEEP);
        cmp_a           = x_reg.key;
        cmp_b           = ram_rdata.key;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = AW'(int'(q_in) * MAX_KEEP);
                if (start && mode != ptkh_pkg::MODE_UNUSED)
                begin
                    q_next     = q_in;
                    n_next     = n_in;
                    drain_next = 1'b0;
                    x_next.key = score_key;
                    x_next.seg = cand_segment;
                    x_next.off = row_offset[31:0];
                    if (bad_query)
                    begin
                        res_valid_next  = 1'b1;
                        res_next        = '0;
                        res_entry_next  = 1'b0;
                        res_status_next = ptkh_pkg::STATUS_BAD_QUERY;
                        res_last_next   = 1'b1;
                    end
                    else if (mode == ptkh_pkg::MODE_INSERT)
                    begin
                        if (!row_offset[32])
                        begin
                            if (n_in < keep_eff)
                            begin
                                fill_we    = 1'b1;
                                fill_q     = q_in;
                                fill_val   = n_in + FW'(1);
                                h_next     = IW'(n_in);
                                state_next = ST_UP;
                            end
                            else if (n_in != '0)
                            begin
                                state_next = ST_ROOT_CMP;
                            end
                        end
                    end
                    else if (mode == ptkh_pkg::MODE_THRESHOLD)
                    begin
                        if (n_in >= keep_eff)
                        begin
                            state_next = ST_TH;
                        end
                        else
                        begin
                            res_valid_next  = 1'b1;
                            res_next        = '0;
                            res_next.key    = ptkh_pkg::KEY_MIN;
                            res_entry_next  = 1'b0;
                            res_status_next = ptkh_pkg::STATUS_OK;
                            res_last_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        if (n_in == '0)
                        begin
                            res_valid_next  = 1'b1;
                            res_next        = '0;
                            res_entry_next  = 1'b0;
                            res_status_next = ptkh_pkg::STATUS_OK;
                            res_last_next   = 1'b1;
                        end
                        else
                        begin
                            drain_next = 1'b1;
                            state_next = ST_DR_RD;
                        end
                    end
                end
            end
            ST_ROOT_CMP:
            begin
                // root is on the read data; replace only on a strictly better key
                cmp_a = ram_rdata.key;
                cmp_b = x_reg.key;
                if (cmp_less)
                begin
                    h_next     = '0;
                    state_next = ST_DN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UP:
            begin
                ram_raddr = AW'(int'(q_reg) * MAX_KEEP + int'(parent_idx));
                if (h_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_less)
                begin
                    ram_wdata  = ram_rdata;
                    h_next     = parent_idx;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DN:
            begin
                ram_raddr = AW'(int'(q_reg) * MAX_KEEP + int'(l_idx));
                if (l_idx >= CW'(n_reg))
                begin
                    ram_we     = 1'b1;
                    state_next = drain_reg ? ST_DR_RD : ST_IDLE;
                end
                else
                begin
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L:
            begin
                left_next = ram_rdata;
                ram_raddr = AW'(int'(q_reg) * MAX_KEEP + int'(r_idx));
                if (r_idx < CW'(n_reg))
                begin
                    state_next = ST_DN_R;
                end
                else
                begin
                    // single child: compare it against the moving entry
                    ram_we = 1'b1;
                    cmp_a  = ram_rdata.key;
                    cmp_b  = x_reg.key;
                    if (cmp_less)
                    begin
                        ram_wdata  = ram_rdata;
                        h_next     = IW'(l_idx);
                        state_next = ST_DN;
                    end
                    else
                    begin
                        state_next = drain_reg ? ST_DR_RD : ST_IDLE;
                    end
                end
            end
            ST_DN_R:
            begin
                // right wins only when strictly smaller
                cmp_a = ram_rdata.key;
                cmp_b = left_reg.key;
                if (cmp_less)
                begin
                    left_next = ram_rdata;
                    c_next    = IW'(r_idx);
                end
                else
                begin
                    c_next    = IW'(l_idx);
                end
                state_next = ST_DN_C;
            end
            ST_DN_C:
            begin
                // smaller child against the moving entry
                ram_we = 1'b1;
                cmp_a  = left_reg.key;
                cmp_b  = x_reg.key;
                if (cmp_less)
                begin
                    ram_wdata  = left_reg;
                    h_next     = c_reg;
                    state_next = ST_DN;
                end
                else
                begin
                    state_next = drain_reg ? ST_DR_RD : ST_IDLE;
                end
            end
            ST_TH:
            begin
                res_valid_next  = 1'b1;
                res_next        = '0;
                res_next.key    = ram_rdata.key;
                res_entry_next  = 1'b0;
                res_status_next = ptkh_pkg::STATUS_OK;
                res_last_next   = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_DR_RD:
            begin
                state_next = ST_DR_OUT;
            end
            ST_DR_OUT:
            begin
                res_valid_next  = 1'b1;
                res_next        = ram_rdata;
                res_entry_next  = 1'b1;
                res_status_next = ptkh_pkg::STATUS_OK;
                res_last_next   = (n_reg == FW'(1));
                n_next          = n_reg - FW'(1);
                ram_raddr       = AW'(int'(q_reg) * MAX_KEEP + int'(n_reg) - 1);
                if (n_reg == FW'(1))
                begin
                    fill_we    = 1'b1;
                    fill_val   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DR_MOV;
                end
            end
            ST_DR_MOV:
            begin
                x_next     = ram_rdata;
                h_next     = '0;
                state_next = ST_DN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keep_reg       <= 7'd10;
            active_reg     <= 5'd1;
            drain_reg      <= 1'b0;
            q_reg          <= '0;
            n_reg          <= '0;
            h_reg          <= '0;
            c_reg          <= '0;
            x_reg          <= '0;
            left_reg       <= '0;
            res_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_entry_reg  <= 1'b0;
            res_status_reg <= 1'b0;
            res_last_reg   <= 1'b0;
            for (int i = 0; i < MAX_QUERIES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            drain_reg      <= drain_next;
            q_reg          <= q_next;
            n_reg          <= n_next;
            h_reg          <= h_next;
            c_reg          <= c_next;
            x_reg          <= x_next;
            left_reg       <= left_next;
            res_reg        <= res_next;
            res_valid_reg  <= res_valid_next;
            res_entry_reg  <= res_entry_next;
            res_status_reg <= res_status_next;
            res_last_reg   <= res_last_next;
            if (fill_we)
            begin
                fill_reg[fill_q] <= fill_val;
            end
            if (cfg_we && cfg_index == ptkh_pkg::REG_KEEP)
            begin
                keep_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == ptkh_pkg::REG_ACTIVE)
            begin
                active_reg <= cfg_data[4:0];
            end
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign out_key      = res_reg.key;
    assign out_segment  = res_reg.seg;
    assign out_offset   = res_reg.off;
    assign entry_valid  = res_entry_reg;
    assign status       = res_status_reg;
    assign last_result  = res_last_reg;

endmodule

### src/ptkh_checker.sv
// ---------------------------------------------------------------------------
// ptkh_checker
// Port-level checks on the per-query top-k heap, bound to the top level.
// ---------------------------------------------------------------------------
module ptkh_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] mode,
    input logic       result_valid,
    input logic       entry_valid,
    input logic       status,
    input logic       last_result
);

    // unused mode code gives no transfer
    a_unused_mode_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == ptkh_pkg::MODE_UNUSED) |=> !result_valid)
        else $error("result after unused mode");

    a_bad_query_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (last_result && !entry_valid))
        else $error("error status result not final");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !entry_valid) |-> last_result)
        else $error("entry-less result not final");

    // threshold answers at once or goes busy to read the root
    a_threshold_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == ptkh_pkg::MODE_THRESHOLD)
            |=> ((result_valid && last_result) || busy))
        else $error("threshold item dropped");

endmodule

bind per_query_topk_heap ptkh_checker u_ptkh_checker (.*);

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-query top-k heap: a scoreboard keeps its
// own copy of every heap, predicts the strobed results of each transfer and
// compares them field by field while directed and random traffic runs
// under several register settings.
// ---------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int SLOTS       = 64;
    localparam int QUERIES     = 16;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] key;
        logic [62:0] seg;
        logic [31:0] off;
        logic        ev;
        logic        st;
        logic        last;
    } heap_result_t;

    class topk_scoreboard;
        logic [31:0] keys [QUERIES][SLOTS];
        logic [62:0] segs [QUERIES][SLOTS];
        logic [31:0] offs [QUERIES][SLOTS];
        int fill [QUERIES];
        int keep_reg;
        int active_reg;
        heap_result_t pending [$];
        int errors;
        int checked;

        function new();
            keep_reg = 10;
            active_reg = 1;
            errors = 0;
            checked = 0;
            foreach (fill[i]) fill[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [6:0] val);
            if (idx == ptkh_pkg::REG_KEEP) keep_reg = val;
            else if (idx == ptkh_pkg::REG_ACTIVE) active_reg = val[4:0];
        endfunction

        function int eff_keep();
            if (keep_reg < 1) return 1;
            if (keep_reg > SLOTS) return SLOTS;
            return keep_reg;
        endfunction

        function int eff_active();
            if (active_reg < 1) return 1;
            if (active_reg > QUERIES) return QUERIES;
            return active_reg;
        endfunction

        function bit key_lt(logic [31:0] a, logic [31:0] b);
            return $signed(a) < $signed(b);
        endfunction

        function void swap_slots(int q, int a, int b);
            logic [31:0] k;
            logic [62:0] s;
            logic [31:0] o;
            k = keys[q][a]; s = segs[q][a]; o = offs[q][a];
            keys[q][a] = keys[q][b]; segs[q][a] = segs[q][b]; offs[q][a] = offs[q][b];
            keys[q][b] = k; segs[q][b] = s; offs[q][b] = o;
        endfunction

        function void sift_up(int q, int i);
            int p;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!key_lt(keys[q][i], keys[q][p])) break;
                swap_slots(q, i, p);
                i = p;
            end
        endfunction

        function void sift_down(int q, int n, int i);
            int l;
            int c;
            forever begin
                l = 2 * i + 1;
                if (l >= n) break;
                c = l;
                // left child wins a tie
                if (l + 1 < n && key_lt(keys[q][l+1], keys[q][l])) c = l + 1;
                if (!key_lt(keys[q][c], keys[q][i])) break;
                swap_slots(q, c, i);
                i = c;
            end
        endfunction

        function void add_result(logic [31:0] k, logic [62:0] s, logic [31:0] o,
                                 logic ev, logic st, logic last);
            heap_result_t r;
            r.key = k; r.seg = s; r.off = o; r.ev = ev; r.st = st; r.last = last;
            pending = {pending, r};
        endfunction

        function void note_input(logic [1:0] m, logic [3:0] q, logic [31:0] k,
                                 logic [62:0] s, logic [32:0] o);
            int n;
            if (m == ptkh_pkg::MODE_UNUSED) return;
            if (q >= eff_active()) begin
                add_result('0, '0, '0, 1'b0, ptkh_pkg::STATUS_BAD_QUERY, 1'b1);
                return;
            end
            n = fill[q];
            if (m == ptkh_pkg::MODE_INSERT) begin
                if (o[32]) return;
                if (n < eff_keep()) begin
                    keys[q][n] = k; segs[q][n] = s; offs[q][n] = o[31:0];
                    fill[q] = n + 1;
                    sift_up(q, n);
                end else if (n > 0 && key_lt(keys[q][0], k)) begin
                    keys[q][0] = k; segs[q][0] = s; offs[q][0] = o[31:0];
                    sift_down(q, n, 0);
                end
            end else if (m == ptkh_pkg::MODE_THRESHOLD) begin
                add_result((n >= eff_keep()) ? keys[q][0] : ptkh_pkg::KEY_MIN, '0, '0,
                           1'b0, ptkh_pkg::STATUS_OK, 1'b1);
            end else if (n == 0) begin
                add_result('0, '0, '0, 1'b0, ptkh_pkg::STATUS_OK, 1'b1);
            end else begin
                while (n > 0) begin
                    add_result(keys[q][0], segs[q][0], offs[q][0], 1'b1,
                               ptkh_pkg::STATUS_OK, n == 1);
                    n--;
                    if (n > 0) begin
                        keys[q][0] = keys[q][n]; segs[q][0] = segs[q][n];
                        offs[q][0] = offs[q][n];
                        sift_down(q, n, 0);
                    end
                end
                fill[q] = 0;
            end
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(heap_result_t got);
            heap_result_t exp;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result key=%h", got.key));
                return;
            end
            exp = pending.pop_front();
            if (got.key !== exp.key)
                report($sformatf("out_key %h, expected %h", got.key, exp.key));
            if (got.seg !== exp.seg)
                report($sformatf("out_segment %h, expected %h", got.seg, exp.seg));
            if (got.off !== exp.off)
                report($sformatf("out_offset %h, expected %h", got.off, exp.off));
            if (got.ev !== exp.ev)
                report($sformatf("entry_valid %b, expected %b", got.ev, exp.ev));
            if (got.st !== exp.st)
                report($sformatf("status %b, expected %b", got.st, exp.st));
            if (got.last !== exp.last)
                report($sformatf("last_result %b, expected %b", got.last, exp.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [3:0]  query_index;
    logic signed [31:0] score_key;
    logic [62:0] cand_segment;
    logic signed [32:0] row_offset;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        result_valid;
    logic signed [31:0] out_key;
    logic [62:0] out_segment;
    logic [31:0] out_offset;
    logic        entry_valid;
    logic        status;
    logic        last_result;

    topk_scoreboard sb = new();
    int items_sent = 0;
    int cycles = 0;

    per_query_topk_heap dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .query_index(query_index), .score_key(score_key),
        .cand_segment(cand_segment), .row_offset(row_offset),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .out_key(out_key), .out_segment(out_segment),
        .out_offset(out_offset), .entry_valid(entry_valid), .status(status),
        .last_result(last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        heap_result_t got;
        if (rst_n && result_valid === 1'b1)
        begin
            got.key = out_key; got.seg = out_segment; got.off = out_offset;
            got.ev = entry_valid; got.st = status; got.last = last_result;
            sb.check_result(got);
        end
    end

    // one transfer; called right after a rising edge
    task send_item(logic [1:0] m, logic [3:0] q, logic [31:0] k, logic [62:0] s,
                   logic [32:0] o, int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        mode <= m; query_index <= q; score_key <= k; cand_segment <= s; row_offset <= o;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_input(m, q, k, s, o);
        items_sent++;
    endtask

    task settle();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // leaves the write enable high; caller lowers it
    task cfg_write(logic [1:0] idx, logic [6:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task configure(int keep, int active);
        settle();
        cfg_write(ptkh_pkg::REG_KEEP, 7'(keep));
        cfg_write(ptkh_pkg::REG_ACTIVE, 7'(active));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task send_random(int idle_pct);
        int r;
        logic [1:0] m;
        logic [3:0] q;
        logic [31:0] k;
        logic [32:0] o;
        r = $urandom_range(99);
        m = (r < 62) ? ptkh_pkg::MODE_INSERT : (r < 80) ? ptkh_pkg::MODE_THRESHOLD :
            (r < 96) ? ptkh_pkg::MODE_DRAIN : ptkh_pkg::MODE_UNUSED;
        q = ($urandom_range(9) == 0) ? 4'($urandom) :
            4'($urandom_range(sb.eff_active() - 1));
        // narrow key range now and then to force ties
        k = ($urandom_range(3) == 0) ? 32'($signed($urandom_range(8)) - 4) : $urandom;
        r = $urandom_range(99);
        o = (r < 3) ? '1 : (r < 6) ? {1'b1, 32'($urandom)} : {1'b0, 32'($urandom)};
        send_item(m, q, k, {31'($urandom), 32'($urandom)}, o, idle_pct);
    endtask

    initial
    begin
        int idle;
        int phase;
        int keeps [7];
        int acts [7];
        start = 1'b0; mode = ptkh_pkg::MODE_INSERT; query_index = '0; score_key = '0;
        cand_segment = '0; row_offset = '0; cfg_we = 1'b0; cfg_index = ptkh_pkg::REG_KEEP;
        cfg_data = '0; rst_n = 1'b0;
        keeps = '{10, 64, 1, 0, 127, 5, 3};
        acts = '{1, 16, 4, 3, 31, 0, 8};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults after reset, threshold before full
        send_item(ptkh_pkg::MODE_THRESHOLD, 4'd0, '0, '0, '0, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd1, 32'd5, 63'd1, 33'd1, 0);
        configure(3, 2);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'h7fff_ffff, '1, 33'h0_ffff_ffff, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, ptkh_pkg::KEY_MIN, '0, '0, 0);
        send_item(ptkh_pkg::MODE_THRESHOLD, 4'd0, '0, '0, '0, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'd7, 63'h5555, 33'd9, 0);
        send_item(ptkh_pkg::MODE_THRESHOLD, 4'd0, '0, '0, '0, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, ptkh_pkg::KEY_MIN, 63'd3, 33'd3, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'd7, 63'd4, 33'd4, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'd100, 63'd5, 33'd5, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'd1000, 63'd6, 33'd6, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'd2000, 63'd7, 33'd7, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'h7fff_ffff, 63'd8, '1, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd0, 32'h7fff_ffff, 63'd9, {1'b1, 32'h0}, 0);
        send_item(ptkh_pkg::MODE_UNUSED, 4'd0, 32'd1, 63'd1, 33'd1, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd2, 32'd1, 63'd1, 33'd1, 0);
        send_item(ptkh_pkg::MODE_THRESHOLD, 4'd15, 32'd1, 63'd1, 33'd1, 0);
        send_item(ptkh_pkg::MODE_DRAIN, 4'd2, 32'd1, 63'd1, 33'd1, 0);
        send_item(ptkh_pkg::MODE_DRAIN, 4'd0, '0, '0, '0, 0);
        send_item(ptkh_pkg::MODE_DRAIN, 4'd0, '0, '0, '0, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd1, 32'd10, 63'd1, 33'd1, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd1, 32'd20, 63'd2, 33'd2, 0);
        send_item(ptkh_pkg::MODE_INSERT, 4'd1, 32'd30, 63'd3, 33'd3, 0);
        // lowered keep count leaves the heap over-full
        configure(1, 2);
        settle();
        cfg_write(REG_SPARE_A, 7'h7f);
        cfg_write(REG_SPARE_B, 7'h00);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_item(ptkh_pkg::MODE_INSERT, 4'd1, 32'd25, 63'd4, 33'd4, 0);
        send_item(ptkh_pkg::MODE_THRESHOLD, 4'd1, '0, '0, '0, 0);
        send_item(ptkh_pkg::MODE_DRAIN, 4'd1, '0, '0, '0, 0);

        for (phase = 0; phase < 7; phase++)
        begin
            configure(keeps[phase], acts[phase]);
            idle = (phase < 2) ? 37 : (phase < 4) ? 52 : 0;
            repeat (39) send_random(idle);
            for (int q = 0; q < sb.eff_active(); q++)
                send_item(ptkh_pkg::MODE_DRAIN, 4'(q), '0, '0, '0, idle);
        end

        settle();
        $display("%0d transfers sent, %0d results checked over 7 register settings",
                 items_sent, sb.checked);
        $display("inserts, thresholds, drains, bad queries and placeholders exercised");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
